// ===== rtl/pol_pkg.sv =====
package pol_pkg;

   localparam int CAPACITY_DEFAULT = 32;
   localparam int DATA_W           = 32;
   localparam int POS_W            = 6;
   localparam int COUNT_FIELD_W    = 6;

   typedef enum logic [2:0] {
      OP_INS_FRONT = 3'd0,
      OP_INS_BACK  = 3'd1,
      OP_INS_AT    = 3'd2,
      OP_DEL_FRONT = 3'd3,
      OP_DEL_BACK  = 3'd4,
      OP_DEL_AT    = 3'd5,
      OP_DUMP      = 3'd6
   } op_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_BADPOS = 2'd1,
      STATUS_EMPTY  = 2'd2,
      STATUS_FULL   = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      CELL_HOLD,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   typedef struct packed {
      cell_op_type              op;
      logic signed [DATA_W-1:0] value;
   } cell_cmd_type;

   typedef enum logic [1:0] {
      FSM_IDLE,
      FSM_SEND,
      FSM_DUMP
   } state_type;

endpackage

// ===== rtl/positional_ordered_list.sv =====
// positional ordered list: up to CAPACITY signed 32-bit values kept front to back
// in a row of cells; every edit shifts the cells at and beyond its position at once.
// request channel (req_*): one transaction per operation; tuser carries the
// operation code, tdata the position and the value to insert.
// response channel (rsp_*): tuser carries the status, tdata the count and the
// element, tlast marks the final response of an operation.
// an edit's single response is shown in the cycle after the edit is taken.
// a dump shows one stored value per cycle while the receiver is ready, front to
// back, by rotating the occupied cells toward the front.
// a new request is taken only after all responses of the previous one are out.
// when the receiver holds rsp_tready low the response stays put and the cells
// do not move.
// reset empties the list; cell contents are not cleared and are never read
// before they are written.
module positional_ordered_list #(
   parameter int CAPACITY = pol_pkg::CAPACITY_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // position[5:0], value[37:6], zero pad
   input  logic [2:0]  req_tuser,   // operation[2:0]
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // count[5:0], element[37:6], zero pad
   output logic [1:0]  rsp_tuser,   // status[1:0]
   output logic        rsp_tlast
);

   localparam int DW    = pol_pkg::DATA_W;
   localparam int IDX_W = $clog2(CAPACITY);
   localparam int CNT_W = $clog2(CAPACITY + 1);
   localparam int CMP_W = ((CNT_W > pol_pkg::POS_W) ? CNT_W : pol_pkg::POS_W) + 1;

   pol_pkg::state_type  state_ff, state_in;
   pol_pkg::status_type status_ff, status_in;
   logic [CNT_W-1:0]    count_ff, count_in;
   logic [CNT_W-1:0]    remaining_ff, remaining_in;

   pol_pkg::op_type           req_op;
   logic [pol_pkg::POS_W-1:0] req_position;
   logic signed [DW-1:0]      req_value;
   logic                      req_accept;

   pol_pkg::status_type  dec_status;
   pol_pkg::cell_op_type dec_cell_op;
   logic [IDX_W-1:0]     dec_target;
   logic [CNT_W-1:0]     dec_count;
   pol_pkg::state_type   dec_state;

   logic [CMP_W-1:0] pos_ext;
   logic [CMP_W-1:0] cnt_ext;
   logic             is_full;
   logic             is_empty;

   pol_pkg::cell_cmd_type cmd;
   logic [IDX_W-1:0]      tail;
   logic signed [DW-1:0]  cell_value [CAPACITY];
   logic                  dump_last;

   assign req_op       = pol_pkg::op_type'(req_tuser);
   assign req_position = req_tdata[5:0];
   assign req_value    = req_tdata[37:6];
   assign req_accept   = req_tvalid && req_tready;

   assign pos_ext  = CMP_W'(req_position);
   assign cnt_ext  = CMP_W'(count_ff);
   assign is_full  = (cnt_ext == CMP_W'(CAPACITY));
   assign is_empty = (count_ff == '0);

   // operation decode and status
   always_comb begin
      dec_status  = pol_pkg::STATUS_OK;
      dec_cell_op = pol_pkg::CELL_HOLD;
      dec_target  = '0;
      dec_count   = count_ff;
      dec_state   = pol_pkg::FSM_SEND;
      case (req_op)
         pol_pkg::OP_INS_FRONT, pol_pkg::OP_INS_BACK: begin
            if (is_full) begin
               dec_status = pol_pkg::STATUS_FULL;
            end else begin
               dec_cell_op = pol_pkg::CELL_INSERT;
               dec_target  = (req_op == pol_pkg::OP_INS_FRONT) ? '0 : IDX_W'(count_ff);
               dec_count   = count_ff + CNT_W'(1);
            end
         end
         pol_pkg::OP_INS_AT: begin
            if (pos_ext == '0 || pos_ext > cnt_ext + CMP_W'(1)) begin
               dec_status = pol_pkg::STATUS_BADPOS;
            end else if (is_full) begin
               dec_status = pol_pkg::STATUS_FULL;
            end else begin
               dec_cell_op = pol_pkg::CELL_INSERT;
               dec_target  = IDX_W'(pos_ext - CMP_W'(1));
               dec_count   = count_ff + CNT_W'(1);
            end
         end
         pol_pkg::OP_DEL_FRONT, pol_pkg::OP_DEL_BACK: begin
            if (is_empty) begin
               dec_status = pol_pkg::STATUS_EMPTY;
            end else begin
               dec_cell_op = pol_pkg::CELL_DELETE;
               dec_target  = (req_op == pol_pkg::OP_DEL_FRONT) ? '0
                                                               : IDX_W'(count_ff - CNT_W'(1));
               dec_count   = count_ff - CNT_W'(1);
            end
         end
         pol_pkg::OP_DEL_AT: begin
            if (pos_ext == '0 || pos_ext > cnt_ext) begin
               dec_status = pol_pkg::STATUS_BADPOS;
            end else begin
               dec_cell_op = pol_pkg::CELL_DELETE;
               dec_target  = IDX_W'(pos_ext - CMP_W'(1));
               dec_count   = count_ff - CNT_W'(1);
            end
         end
         pol_pkg::OP_DUMP: begin
            if (is_empty) begin
               dec_status = pol_pkg::STATUS_EMPTY;
            end else begin
               dec_state = pol_pkg::FSM_DUMP;
            end
         end
         default: begin
            dec_status = pol_pkg::STATUS_BADPOS;
         end
      endcase
   end

   assign dump_last = (remaining_ff == CNT_W'(1));
   assign tail      = IDX_W'(count_ff - CNT_W'(1));

   // next state
   always_comb begin
      state_in     = state_ff;
      status_in    = status_ff;
      count_in     = count_ff;
      remaining_in = remaining_ff;
      case (state_ff)
         pol_pkg::FSM_IDLE: begin
            if (req_accept) begin
               state_in     = dec_state;
               status_in    = dec_status;
               count_in     = dec_count;
               remaining_in = count_ff;
            end
         end
         pol_pkg::FSM_SEND: begin
            if (rsp_tready) begin
               state_in = pol_pkg::FSM_IDLE;
            end
         end
         pol_pkg::FSM_DUMP: begin
            if (rsp_tready) begin
               remaining_in = remaining_ff - CNT_W'(1);
               if (dump_last) begin
                  state_in = pol_pkg::FSM_IDLE;
               end
            end
         end
         default: begin
            state_in = pol_pkg::FSM_IDLE;
         end
      endcase
   end

   // outputs and cell command
   always_comb begin
      req_tready = 1'b0;
      rsp_tvalid = 1'b0;
      rsp_tuser  = pol_pkg::STATUS_OK;
      rsp_tdata  = '0;
      rsp_tlast  = 1'b0;
      cmd.op     = pol_pkg::CELL_HOLD;
      cmd.value  = req_value;
      case (state_ff)
         pol_pkg::FSM_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op = dec_cell_op;
            end
         end
         pol_pkg::FSM_SEND: begin
            rsp_tvalid       = 1'b1;
            rsp_tuser        = status_ff;
            rsp_tdata[5:0]   = pol_pkg::COUNT_FIELD_W'(count_ff);
            rsp_tlast        = 1'b1;
         end
         pol_pkg::FSM_DUMP: begin
            rsp_tvalid       = 1'b1;
            rsp_tuser        = pol_pkg::STATUS_OK;
            rsp_tdata[5:0]   = pol_pkg::COUNT_FIELD_W'(count_ff);
            rsp_tdata[37:6]  = cell_value[0];
            rsp_tlast        = dump_last;
            if (rsp_tready) begin
               cmd.op = pol_pkg::CELL_ROTATE;
            end
         end
         default: begin
            req_tready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pol_pkg::FSM_IDLE;
         status_ff    <= pol_pkg::STATUS_OK;
         count_ff     <= '0;
         remaining_ff <= '0;
      end else begin
         state_ff     <= state_in;
         status_ff    <= status_in;
         count_ff     <= count_in;
         remaining_ff <= remaining_in;
      end
   end

   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      logic signed [DW-1:0] left_value;
      logic signed [DW-1:0] right_value;

      if (i == 0) begin : g_first
         assign left_value = '0;
      end else begin : g_inner_left
         assign left_value = cell_value[i-1];
      end

      if (i == CAPACITY - 1) begin : g_last
         assign right_value = '0;
      end else begin : g_inner_right
         assign right_value = cell_value[i+1];
      end

      pol_cell #(
         .IDX_W (IDX_W),
         .INDEX (i)
      ) u_cell (
         .clock       (clock),
         .cmd         (cmd),
         .target      (dec_target),
         .tail        (tail),
         .left_value  (left_value),
         .right_value (right_value),
         .head_value  (cell_value[0]),
         .value_out   (cell_value[i])
      );
   end

endmodule

// ===== rtl/pol_cell.sv =====
module pol_cell #(
   parameter int IDX_W = 5,
   parameter int INDEX = 0
) (
   input  logic                                clock,
   input  pol_pkg::cell_cmd_type               cmd,
   input  logic [IDX_W-1:0]                    target,
   input  logic [IDX_W-1:0]                    tail,
   input  logic signed [pol_pkg::DATA_W-1:0]   left_value,
   input  logic signed [pol_pkg::DATA_W-1:0]   right_value,
   input  logic signed [pol_pkg::DATA_W-1:0]   head_value,
   output logic signed [pol_pkg::DATA_W-1:0]   value_out
);

   localparam logic [IDX_W-1:0] MY_INDEX = IDX_W'(INDEX);

   logic signed [pol_pkg::DATA_W-1:0] value_ff;
   logic signed [pol_pkg::DATA_W-1:0] value_in;

   always_comb begin
      value_in = value_ff;
      case (cmd.op)
         pol_pkg::CELL_INSERT: begin
            if (MY_INDEX > target) begin
               value_in = left_value;
            end else if (MY_INDEX == target) begin
               value_in = cmd.value;
            end
         end
         pol_pkg::CELL_DELETE: begin
            if (MY_INDEX >= target) begin
               value_in = right_value;
            end
         end
         // front value wraps around to the tail of the occupied region
         pol_pkg::CELL_ROTATE: begin
            if (MY_INDEX == tail) begin
               value_in = head_value;
            end else if (MY_INDEX < tail) begin
               value_in = right_value;
            end
         end
         default: begin
            value_in = value_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule

// ===== tb/sv/tb_positional_ordered_list.sv =====
`timescale 1ns / 100ps

module tb_positional_ordered_list;

   localparam int LIST_CAP = pol_pkg::CAPACITY_DEFAULT;
   localparam logic [2:0] OP_UNUSED = 3'd7;
   localparam int MAX_PRINTED = 40;

   typedef struct {
      pol_pkg::status_type status;
      logic [5:0]          count;
      logic [31:0]         element;
      logic                last;
   } list_response_type;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;   // position[5:0], value[37:6], zero pad
   logic [2:0]  req_tuser;   // operation[2:0]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;   // count[5:0], element[37:6], zero pad
   logic [1:0]  rsp_tuser;   // status[1:0]
   logic        rsp_tlast;

   logic [31:0]       shadow_list[$];
   list_response_type awaited_responses[$];
   int                mismatch_count = 0;
   bit                idling_on = 1'b1;
   int                hold_off_cycles = 0;

   positional_ordered_list dut (
      clock,
      reset,
      req_tvalid,
      req_tready,
      req_tdata,
      req_tuser,
      rsp_tvalid,
      rsp_tready,
      rsp_tdata,
      rsp_tuser,
      rsp_tlast
   );

   always #4 clock = ~clock;

   task automatic report_mismatch(input string what, input logic [31:0] wanted,
                                  input logic [31:0] seen);
      mismatch_count++;
      if (mismatch_count <= MAX_PRINTED)
         $display("mismatch on %s at %0t: expected %0h, got %0h", what, $realtime, wanted,
                  seen);
   endtask

   function automatic void expect_response(pol_pkg::status_type st, logic [31:0] elem,
                                           logic last);
      list_response_type r;
      r.status  = st;
      r.count   = 6'(shadow_list.size());
      r.element = elem;
      r.last    = last;
      awaited_responses.push_back(r);
   endfunction

   // keeps the shadow list in step with the block and queues what it must answer
   function automatic void apply_list_op(logic [2:0] op, logic [5:0] pos, logic [31:0] val);
      pol_pkg::status_type st;
      int n;
      st = pol_pkg::STATUS_OK;
      n = shadow_list.size();
      case (op)
         pol_pkg::OP_INS_FRONT, pol_pkg::OP_INS_BACK: begin
            if (n >= LIST_CAP) st = pol_pkg::STATUS_FULL;
            else if (op == pol_pkg::OP_INS_FRONT) shadow_list.push_front(val);
            else shadow_list.push_back(val);
         end
         pol_pkg::OP_INS_AT: begin
            // position check wins over full
            if (pos < 1 || pos > n + 1) st = pol_pkg::STATUS_BADPOS;
            else if (n >= LIST_CAP) st = pol_pkg::STATUS_FULL;
            else shadow_list.insert(pos - 1, val);
         end
         pol_pkg::OP_DEL_FRONT, pol_pkg::OP_DEL_BACK: begin
            if (n == 0) st = pol_pkg::STATUS_EMPTY;
            else if (op == pol_pkg::OP_DEL_FRONT) void'(shadow_list.pop_front());
            else void'(shadow_list.pop_back());
         end
         pol_pkg::OP_DEL_AT: begin
            if (pos < 1 || pos > n) st = pol_pkg::STATUS_BADPOS;
            else shadow_list.delete(pos - 1);
         end
         pol_pkg::OP_DUMP: begin
            if (n == 0) begin
               expect_response(pol_pkg::STATUS_EMPTY, 32'd0, 1'b1);
            end else begin
               for (int i = 0; i < n; i++)
                  expect_response(pol_pkg::STATUS_OK, shadow_list[i], i == n - 1);
            end
            return;
         end
         default: st = pol_pkg::STATUS_BADPOS;
      endcase
      expect_response(st, 32'd0, 1'b1);
   endfunction

   task automatic send_op(input logic [2:0] op, input logic [5:0] pos, input logic [31:0] val);
      if (idling_on && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= op;
      req_tdata  <= {2'b00, val, pos};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      apply_list_op(op, pos, val);
   endtask

   function automatic logic [31:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'h0000_0000;
         3: return 32'hffff_ffff;
         default: return $urandom;
      endcase
   endfunction

   // insert_weight out of 88 sets how hard the list is pushed toward full
   task automatic send_random_op(input int insert_weight);
      int n;
      int roll;
      logic [2:0] op;
      logic [5:0] pos;
      n = shadow_list.size();
      roll = $urandom_range(0, 99);
      if (roll < 2) op = OP_UNUSED;
      else if (roll < 12) op = pol_pkg::OP_DUMP;
      else if (roll < 12 + insert_weight)
         case ($urandom_range(0, 2))
            0: op = pol_pkg::OP_INS_FRONT;
            1: op = pol_pkg::OP_INS_BACK;
            default: op = pol_pkg::OP_INS_AT;
         endcase
      else
         case ($urandom_range(0, 2))
            0: op = pol_pkg::OP_DEL_FRONT;
            1: op = pol_pkg::OP_DEL_BACK;
            default: op = pol_pkg::OP_DEL_AT;
         endcase
      if ($urandom_range(0, 6) == 0) pos = 6'($urandom_range(0, 63));
      else if (op == pol_pkg::OP_INS_AT) pos = 6'($urandom_range(1, n + 1));
      else if (n == 0) pos = 6'd0;
      else pos = 6'($urandom_range(1, n));
      send_op(op, pos, pick_value());
   endtask

   task automatic test_empty_list();
      send_op(pol_pkg::OP_DUMP, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_FRONT, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_BACK, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd1, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd0, 32'd0);
      send_op(pol_pkg::OP_INS_AT, 6'd0, 32'h1234_5678);
      send_op(pol_pkg::OP_INS_AT, 6'd2, 32'h1234_5678);
      send_op(OP_UNUSED, 6'd63, 32'hffff_ffff);
   endtask

   task automatic test_edits();
      send_op(pol_pkg::OP_INS_FRONT, 6'd0, 32'h8000_0000);
      send_op(pol_pkg::OP_INS_BACK, 6'd63, 32'h7fff_ffff);
      send_op(pol_pkg::OP_INS_AT, 6'd2, 32'hffff_ffff);
      send_op(pol_pkg::OP_INS_AT, 6'd4, 32'h0000_0001);
      send_op(pol_pkg::OP_INS_AT, 6'd1, 32'h0000_0000);
      send_op(pol_pkg::OP_INS_AT, 6'd7, 32'h5555_aaaa);
      send_op(pol_pkg::OP_DUMP, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd63, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd6, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd5, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd1, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd2, 32'd0);
      send_op(OP_UNUSED, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DUMP, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_FRONT, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_BACK, 6'd0, 32'd0);
   endtask

   task automatic test_full_list();
      while (shadow_list.size() < LIST_CAP)
         send_op(pol_pkg::OP_INS_BACK, 6'($urandom_range(0, 63)), pick_value());
      send_op(pol_pkg::OP_INS_FRONT, 6'd0, 32'h1111_1111);
      send_op(pol_pkg::OP_INS_BACK, 6'd0, 32'h2222_2222);
      send_op(pol_pkg::OP_INS_AT, 6'd33, 32'h3333_3333);
      send_op(pol_pkg::OP_INS_AT, 6'd34, 32'h3333_3333);
      send_op(pol_pkg::OP_INS_AT, 6'd0, 32'h3333_3333);
      send_op(pol_pkg::OP_DUMP, 6'd0, 32'd0);
      send_op(pol_pkg::OP_DEL_AT, 6'd32, 32'd0);
      send_op(pol_pkg::OP_INS_AT, 6'd32, 32'h8000_0000);
      send_op(pol_pkg::OP_DEL_AT, 6'd33, 32'd0);
      while (shadow_list.size() > 0)
         send_random_op(0);
   endtask

   task automatic test_random_mix();
      // alternate fill and drain phases so the list spends time near both ends
      for (int i = 0; i < 140; i++)
         send_random_op(((i / 35) % 2 == 0) ? 70 : 20);
   endtask

   task automatic test_backpressure();
      hold_off_cycles = 250;
      for (int i = 0; i < 25; i++)
         send_random_op(60);
   endtask

   task automatic test_no_idling();
      idling_on = 1'b0;
      for (int i = 0; i < 50; i++)
         send_random_op(45);
   endtask

   // response sink: random stalls, plus one long hold-off on request
   initial begin
      rsp_tready <= 1'b0;
      forever begin
         @(posedge clock);
         if (hold_off_cycles != 0) begin
            rsp_tready <= 1'b0;
            repeat (hold_off_cycles) @(posedge clock);
            hold_off_cycles = 0;
            rsp_tready <= 1'b1;
         end else if (idling_on && $urandom_range(0, 5) == 0) begin
            rsp_tready <= 1'b0;
            repeat ($urandom_range(1, 19)) @(posedge clock);
            rsp_tready <= 1'b1;
         end else begin
            rsp_tready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      list_response_type head;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (awaited_responses.size() == 0) begin
            report_mismatch("unexpected transaction", 32'd0, rsp_tdata[37:6]);
         end else begin
            head = awaited_responses.pop_front();
            if (rsp_tuser !== head.status)
               report_mismatch("status", 32'(head.status), 32'(rsp_tuser));
            if (rsp_tdata[5:0] !== head.count)
               report_mismatch("count", 32'(head.count), 32'(rsp_tdata[5:0]));
            if (rsp_tdata[37:6] !== head.element)
               report_mismatch("element", head.element, rsp_tdata[37:6]);
            if (rsp_tlast !== head.last)
               report_mismatch("last", 32'(head.last), 32'(rsp_tlast));
         end
      end
   end

   initial begin
      #10_000_000;
      $display("** positional_ordered_list: FAILED **");
      $finish;
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      req_tuser  <= '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_empty_list();
      test_edits();
      test_full_list();
      test_random_mix();
      test_backpressure();
      test_no_idling();
      req_tvalid <= 1'b0;
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (LIST_CAP + 8) @(posedge clock);
      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("** positional_ordered_list: PASSED **");
      end else begin
         $display("** positional_ordered_list: FAILED **");
      end
      $finish;
   end

endmodule
